// ===== hdl/swld_pkg.sv =====
// swld_pkg: shared types, codes and reset values for the sync word deframer
// no dependencies
package swld_pkg;

    localparam int unsigned SYNC_BYTES_DEF = 16;
    localparam int unsigned SYNC_BYTES_MAX = 16;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned TICK_W     = 16;
    localparam int unsigned MAXLEN_W   = 17;
    localparam int unsigned LEN_W      = 32;
    localparam int unsigned STATUS_W   = 3;

    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(64 * 1024);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 3'd5;

    // register reset values
    localparam logic [31:0]         SYNC_0_RST  = 32'd2737986320;
    localparam logic [31:0]         SYNC_1_RST  = 32'd3054049826;
    localparam logic [31:0]         SYNC_2_RST  = 32'd2066108006;
    localparam logic [31:0]         SYNC_3_RST  = 32'd1758981608;
    localparam logic [TICK_W-1:0]   TIMEOUT_RST = 16'd100;
    localparam logic [MAXLEN_W-1:0] MAX_LEN_RST = 17'd65536;

    localparam logic [TICK_W-1:0] TICK_SAT = '1;

    // frame status codes
    localparam logic [STATUS_W-1:0] ST_BODY    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BADLEN  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TO_SYNC = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TO_LEN  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TO_BODY = 3'd4;

    typedef enum logic [2:0] {
        PH_SYNC = 3'b001,
        PH_LEN  = 3'b010,
        PH_BODY = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0]          body_byte;
        logic                body_last;
        logic [STATUS_W-1:0] frame_status;
    } result_t;

endpackage

// ===== hdl/swld_cell.sv =====
// swld_cell: one byte of the sync search window with its byte compare
// depends on nothing; chained by sync_word_length_deframer_unit
module swld_cell (
    input  logic       clk,
    input  logic       shift_en,
    input  logic [7:0] din,
    input  logic [7:0] sync_byte,
    input  logic       match_in,
    output logic [7:0] dout,
    output logic       match_out
);

    logic [7:0] byte_reg;

    // compare against the byte this cell will hold after the shift
    assign match_out = match_in && (din == sync_byte);
    assign dout      = byte_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= din;
        end
    end

endmodule

// ===== hdl/swld_obuf.sv =====
// swld_obuf: two-entry output buffer, output register plus skid entry
// depends on swld_pkg
module swld_obuf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  swld_pkg::result_t  push_data,
    output logic               space,
    output logic               out_valid,
    input  logic               out_ready,
    output swld_pkg::result_t  out_data
);

    logic              main_valid_reg;
    logic              skid_valid_reg;
    swld_pkg::result_t main_reg;
    swld_pkg::result_t skid_reg;
    logic              pop;

    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign pop       = main_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            main_reg <= skid_reg;
        end
        else if (push && (pop || !main_valid_reg))
        begin
            main_reg <= push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

endmodule

// ===== hdl/sync_word_length_deframer_unit.sv =====
// sync_word_length_deframer_unit: sync search, length and body phases
// depends on swld_pkg, swld_cell, swld_obuf
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_ready   command, rx_byte
//  out      source     out_valid / out_ready body_byte, body_last, frame_status
//  cfg      sink       cfg_write             cfg_index, cfg_data
//
// one word is taken per cycle while in_ready is high; its result, if any, is in the output register
// on the next cycle, or waits in the skid entry while the receiver holds off.
// the window compare runs through the cell chain in the accepting cycle.
// in_ready drops only while both output entries hold results not yet taken.
// reset is asynchronous and needs no clearing pass; control and configuration
// registers return to their reset values, window and output data are not reset.
module sync_word_length_deframer_unit #(
    parameter int unsigned SYNC_BYTES = swld_pkg::SYNC_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           command,
    input  logic [7:0]                     rx_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     body_byte,
    output logic                           body_last,
    output logic [swld_pkg::STATUS_W-1:0]  frame_status,
    input  logic                           cfg_write,
    input  logic [swld_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swld_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned FILL_W = $clog2(SYNC_BYTES + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(SYNC_BYTES);
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(SYNC_BYTES - 1);

    // configuration
    logic [3:0][31:0]                 sync_word_reg;
    logic [swld_pkg::TICK_W-1:0]      timeout_reg;
    logic [swld_pkg::MAXLEN_W-1:0]    max_len_reg;

    // deframer state
    swld_pkg::phase_t                 phase_reg, phase_next;
    logic [FILL_W-1:0]                fill_reg, fill_next;
    logic [23:0]                      len_asm_reg, len_asm_next;
    logic [1:0]                       len_cnt_reg, len_cnt_next;
    logic [swld_pkg::MAXLEN_W-1:0]    rem_reg, rem_next;
    logic [swld_pkg::TICK_W-1:0]      ticks_reg, ticks_next;

    logic                             accept;
    logic                             shift_en;
    logic                             res_valid;
    swld_pkg::result_t                res;
    swld_pkg::result_t                out_data;
    logic                             obuf_space;
    logic [swld_pkg::TICK_W-1:0]      ticks_inc;
    logic [swld_pkg::LEN_W-1:0]       len_value;
    logic [swld_pkg::MAXLEN_W-1:0]    rem_dec;
    logic                             window_match;

    logic [SYNC_BYTES:0][7:0]         chain_data;
    logic [SYNC_BYTES:0]              chain_match;

    assign accept   = in_valid && in_ready;
    assign in_ready = obuf_space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg[0] <= swld_pkg::SYNC_0_RST;
            sync_word_reg[1] <= swld_pkg::SYNC_1_RST;
            sync_word_reg[2] <= swld_pkg::SYNC_2_RST;
            sync_word_reg[3] <= swld_pkg::SYNC_3_RST;
            timeout_reg      <= swld_pkg::TIMEOUT_RST;
            max_len_reg      <= swld_pkg::MAX_LEN_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                swld_pkg::REG_SYNC_0:  sync_word_reg[0] <= cfg_data;
                swld_pkg::REG_SYNC_1:  sync_word_reg[1] <= cfg_data;
                swld_pkg::REG_SYNC_2:  sync_word_reg[2] <= cfg_data;
                swld_pkg::REG_SYNC_3:  sync_word_reg[3] <= cfg_data;
                swld_pkg::REG_TIMEOUT: timeout_reg <= cfg_data[swld_pkg::TICK_W-1:0];
                swld_pkg::REG_MAX_LEN: max_len_reg <= cfg_data[swld_pkg::MAXLEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // window: newest byte enters the top cell, oldest sits in cell 0
    assign chain_data[SYNC_BYTES]  = rx_byte;
    assign chain_match[SYNC_BYTES] = 1'b1;

    for (genvar i = 0; i < SYNC_BYTES; i++)
    begin : g_cell
        swld_cell u_cell (
            .clk       (clk),
            .shift_en  (shift_en),
            .din       (chain_data[i+1]),
            .sync_byte (sync_word_reg[i/4][8*(i%4) +: 8]),
            .match_in  (chain_match[i+1]),
            .dout      (chain_data[i]),
            .match_out (chain_match[i])
        );
    end

    assign window_match = chain_match[0];

    assign ticks_inc = (ticks_reg == swld_pkg::TICK_SAT) ? ticks_reg
                                                         : ticks_reg + 1'b1;
    assign len_value = {rx_byte, len_asm_reg};
    assign rem_dec   = (rem_reg == '0) ? rem_reg : rem_reg - 1'b1;

    always_comb
    begin
        phase_next   = phase_reg;
        fill_next    = fill_reg;
        len_asm_next = len_asm_reg;
        len_cnt_next = len_cnt_reg;
        rem_next     = rem_reg;
        ticks_next   = ticks_reg;
        shift_en     = 1'b0;
        res_valid    = 1'b0;
        res          = '0;

        if (accept)
        begin
            if (command)
            begin
                ticks_next = ticks_inc;
                if (ticks_inc >= timeout_reg)
                begin
                    res_valid = 1'b1;
                    unique case (phase_reg)
                        swld_pkg::PH_LEN:  res.frame_status = swld_pkg::ST_TO_LEN;
                        swld_pkg::PH_BODY: res.frame_status = swld_pkg::ST_TO_BODY;
                        default:           res.frame_status = swld_pkg::ST_TO_SYNC;
                    endcase
                    phase_next   = swld_pkg::PH_SYNC;
                    fill_next    = '0;
                    len_asm_next = '0;
                    len_cnt_next = '0;
                    ticks_next   = '0;
                end
            end
            else
            begin
                unique case (phase_reg)
                    swld_pkg::PH_LEN:
                    begin
                        if (len_cnt_reg != 2'd3)
                        begin
                            len_asm_next[8*len_cnt_reg +: 8] = rx_byte;
                            len_cnt_next = len_cnt_reg + 1'b1;
                        end
                        else
                        begin
                            len_asm_next = '0;
                            len_cnt_next = '0;
                            ticks_next   = '0;
                            fill_next    = '0;
                            if (len_value == '0
                                || len_value > swld_pkg::LEN_W'(max_len_reg)
                                || len_value > swld_pkg::LEN_LIMIT)
                            begin
                                res_valid        = 1'b1;
                                res.frame_status = swld_pkg::ST_BADLEN;
                                phase_next       = swld_pkg::PH_SYNC;
                            end
                            else
                            begin
                                phase_next = swld_pkg::PH_BODY;
                                rem_next   = len_value[swld_pkg::MAXLEN_W-1:0];
                            end
                        end
                    end
                    swld_pkg::PH_BODY:
                    begin
                        rem_next         = rem_dec;
                        res_valid        = 1'b1;
                        res.body_byte    = rx_byte;
                        res.frame_status = swld_pkg::ST_BODY;
                        if (rem_dec == '0)
                        begin
                            res.body_last = 1'b1;
                            phase_next    = swld_pkg::PH_SYNC;
                            ticks_next    = '0;
                            fill_next     = '0;
                            len_asm_next  = '0;
                            len_cnt_next  = '0;
                        end
                    end
                    default:
                    begin
                        shift_en = 1'b1;
                        if (fill_reg < FILL_FULL)
                        begin
                            fill_next = fill_reg + 1'b1;
                        end
                        // compare only once the window is full after this byte
                        if (fill_reg >= FILL_LAST && window_match)
                        begin
                            phase_next   = swld_pkg::PH_LEN;
                            fill_next    = '0;
                            ticks_next   = '0;
                            len_asm_next = '0;
                            len_cnt_next = '0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= swld_pkg::PH_SYNC;
            fill_reg    <= '0;
            len_asm_reg <= '0;
            len_cnt_reg <= '0;
            rem_reg     <= '0;
            ticks_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            fill_reg    <= fill_next;
            len_asm_reg <= len_asm_next;
            len_cnt_reg <= len_cnt_next;
            rem_reg     <= rem_next;
            ticks_reg   <= ticks_next;
        end
    end

    swld_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (obuf_space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign body_byte    = out_data.body_byte;
    assign body_last    = out_data.body_last;
    assign frame_status = out_data.frame_status;

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("window fill beyond window size");

    a_window_empty: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != swld_pkg::PH_SYNC |-> fill_reg == '0)
        else $error("window not emptied outside sync search");

    a_body_rem: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == swld_pkg::PH_BODY |-> rem_reg != '0)
        else $error("body phase with no bytes remaining");

    a_len_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != swld_pkg::PH_LEN |-> len_cnt_reg == '0 && len_asm_reg == '0)
        else $error("length assembly left over outside length phase");

    a_status_resync: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.frame_status != swld_pkg::ST_BODY
        |=> phase_reg == swld_pkg::PH_SYNC && ticks_reg == '0)
        else $error("status result without return to sync search");

endmodule
